// File: rtl/core/implicit_diffusion_line_solver_macros.svh
// Assertion macros for the line solver
`ifndef IMPLICIT_DIFFUSION_LINE_SOLVER_MACROS_SVH
`define IMPLICIT_DIFFUSION_LINE_SOLVER_MACROS_SVH
`ifndef SYNTHESIS
`define IDLS_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("idls check failed");
`define IDLS_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("idls illegal state");
`else
`define IDLS_ASSERT_IMPL(label, clk, rst_n, prop)
`define IDLS_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: rtl/core/idls_pkg.sv
// ----------------------------------------------------------------------------
// idls_pkg
// Shared constants and types of the implicit diffusion line solver.
// ----------------------------------------------------------------------------
package idls_pkg;
	localparam int LINE_MAX_DEF = 64;
	localparam logic [1:0] REG_DIFF  = 2'd0;
	localparam logic [1:0] REG_DECAY = 2'd1;
	localparam logic [1:0] REG_LEN   = 2'd2;
	localparam logic [40:0] ONE_Q24 = 41'h1_000_000;

	// classified sample handed from front to back
	typedef struct packed {
		logic [31:0] density;
		logic        first;
		logic        close;
		logic        endv;
		logic        single;
	} item_t;
endpackage

// File: rtl/core/implicit_diffusion_line_solver.sv
// ----------------------------------------------------------------------------
// implicit_diffusion_line_solver
// Thomas-algorithm solver for one line of an implicit diffusion-decay step.
// ----------------------------------------------------------------------------
// Usage: write diff_coef (0), decay_coef (1) and line_length (2) through the
// cfg port while idle. Feed density words on in_valid/in_stall in voxel order.
// In the back end, two 67-step restoring divisions (eliminated sample and
// upper factor) of each word share one divider. A two-entry queue lets the
// front take words while the back end is busy. The word that closes a line
// starts back substitution (read, multiply, write per voxel), then the line
// is emitted in index order (load, then hold while out_stall is high), with last
// set on the final voxel. out_stall holds the current word; nothing is lost.
// Reset clears control state and registers to their reset values; the
// sample stores need no clearing since every read entry was written first.
// ----------------------------------------------------------------------------
module implicit_diffusion_line_solver #(
	parameter int LINE_MAX = idls_pkg::LINE_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] density_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  voxel_pos,
	output logic [31:0] density_out,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	logic [31:0] diff_q, decay_q;
	logic [6:0]  len_q;
	logic        qv, qt;
	idls_pkg::item_t qi;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_q <= '0;
			decay_q <= '0;
			len_q <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				idls_pkg::REG_DIFF:  diff_q <= cfg_data;
				idls_pkg::REG_DECAY: decay_q <= cfg_data;
				idls_pkg::REG_LEN:   len_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	idls_front #(.LINE_MAX(LINE_MAX)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .density_in,
		.line_length(len_q), .q_valid(qv), .q_item(qi), .q_take(qt)
	);

	idls_back #(.LINE_MAX(LINE_MAX)) u_back (
		.clk, .arst_n, .diff_coef(diff_q), .decay_coef(decay_q),
		.q_valid(qv), .q_item(qi), .q_take(qt), .out_valid, .out_stall,
		.voxel_pos, .density_out, .last
	);
endmodule

// File: rtl/core/idls_front.sv
// ----------------------------------------------------------------------------
// idls_front
// Accepts samples, tracks the fill position, marks first, end and closing voxels,
// and queues them for the back end.
// ----------------------------------------------------------------------------
module idls_front #(
	parameter int LINE_MAX = idls_pkg::LINE_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        density_in,
	input  logic [6:0]         line_length,
	output logic               q_valid,
	output idls_pkg::item_t    q_item,
	input  logic               q_take
);
	localparam int DEPTH = 2;
	localparam int CW = $clog2(LINE_MAX + 1);

	idls_pkg::item_t fifo_q [DEPTH];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	logic [CW-1:0]   fill_q;
	logic [6:0]      len_c;
	logic [CW-1:0]   idx_c;
	logic            endv_c, close_c, acc;
	idls_pkg::item_t it_c;

	always_comb begin
		len_c = line_length;
		if (len_c == 7'd0) len_c = 7'd1;
		if (len_c > 7'(LINE_MAX)) len_c = 7'(LINE_MAX);
		idx_c = (fill_q >= CW'(LINE_MAX)) ? CW'(LINE_MAX - 1) : fill_q;
		close_c = (7'(idx_c) + 7'd1) >= len_c;
		endv_c = (idx_c == '0) || close_c;
		it_c.density = density_in;
		it_c.first = (idx_c == '0);
		it_c.close = close_c;
		it_c.endv = endv_c;
		// a one-cell line has no coupling term on its diagonal
		it_c.single = (len_c == 7'd1);
	end

	assign in_stall = (cnt_q == 2'(DEPTH));
	assign acc = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (acc) fifo_q[wp_q] <= it_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
			fill_q <= '0;
		end else begin
			if (acc) begin
				wp_q <= ~wp_q;
				fill_q <= close_c ? '0 : idx_c + CW'(1);
			end
			if (q_take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(acc) - 2'(q_take);
		end
	end
endmodule

// File: rtl/core/idls_back.sv
// ----------------------------------------------------------------------------
// idls_back
// Forward elimination with a shared restoring divider, then back substitution
// and emission of the line in index order.
// ----------------------------------------------------------------------------
`include "implicit_diffusion_line_solver_macros.svh"
module idls_back #(
	parameter int LINE_MAX = idls_pkg::LINE_MAX_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [31:0]     diff_coef,
	input  logic [31:0]     decay_coef,
	input  logic            q_valid,
	input  idls_pkg::item_t q_item,
	output logic            q_take,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [5:0]      voxel_pos,
	output logic [31:0]     density_out,
	output logic            last
);
	localparam int AW = $clog2(LINE_MAX);
	localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_MUL = 4'd2, S_DEN = 4'd3,
		S_DIV = 4'd4, S_WR = 4'd5, S_BRD = 4'd6, S_BMUL = 4'd7, S_BWR = 4'd8,
		S_ORD = 4'd9, S_OUT = 4'd10;

	logic [31:0] e_mem [LINE_MAX];
	logic [31:0] u_mem [LINE_MAX];
	logic [3:0]  st_q;
	logic [AW-1:0] idx_q, j_q, n1_q;
	idls_pkg::item_t it_q;
	logic [31:0] e_rd_q, u_rd_q, xn_q;
	logic [63:0] p1_q, p2_q;
	logic [40:0] den_q, diag_q;
	logic [66:0] rem_q;   // shared for both divisions
	logic [65:0] qe_q, qu_q;
	logic [6:0]  bit_q;
	logic        phase_q; // 0: sample quotient, 1: upper factor
	logic [66:0] dividend_q;
	logic [31:0] e_res, u_res;
	logic [40:0] sub_c, dm1_c;
	logic [67:0] trial_c;
	logic [40:0] xs_c;

	assign q_take = (st_q == S_IDLE) && q_valid;
	assign sub_c = 41'(p1_q >> 24);
	assign dm1_c = diag_q - idls_pkg::ONE_Q24;
	assign trial_c = {rem_q, dividend_q[66]};
	assign e_res = (qe_q > 66'hFFFF_FFFF) ? 32'hFFFF_FFFF : qe_q[31:0];
	assign u_res = (qu_q > 66'hFFFF_FFFF) ? 32'hFFFF_FFFF : qu_q[31:0];
	assign xs_c = 41'(e_rd_q) + 41'(p1_q >> 24);

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				it_q <= q_item;
				diag_q <= idls_pkg::ONE_Q24 + 41'(decay_coef) +
					(q_item.single ? 41'd0 :
					(q_item.endv ? 41'(diff_coef) : 41'({diff_coef, 1'b0})));
			end
			S_RD: begin
				e_rd_q <= e_mem[idx_q - AW'(1)];
				u_rd_q <= u_mem[idx_q - AW'(1)];
			end
			S_MUL: begin
				p1_q <= it_q.first ? 64'd0 : 64'(diff_coef) * 64'(u_rd_q);
				p2_q <= it_q.first ? 64'd0 : 64'(diff_coef) * 64'(e_rd_q);
			end
			S_DEN: begin
				den_q <= (sub_c > dm1_c) ? idls_pkg::ONE_Q24 : diag_q - sub_c;
				dividend_q <= {2'b0, 41'(it_q.density) + 41'(p2_q >> 24), 24'd0};
				rem_q <= '0;
				bit_q <= 7'd67;
				phase_q <= 1'b0;
			end
			S_DIV: begin
				if (bit_q != 7'd0) begin
					dividend_q <= dividend_q << 1;
					if (trial_c >= 68'(den_q)) begin
						rem_q <= 67'(trial_c - 68'(den_q));
						if (phase_q) qu_q <= {qu_q[64:0], 1'b1};
						else qe_q <= {qe_q[64:0], 1'b1};
					end else begin
						rem_q <= 67'(trial_c);
						if (phase_q) qu_q <= {qu_q[64:0], 1'b0};
						else qe_q <= {qe_q[64:0], 1'b0};
					end
					bit_q <= bit_q - 7'd1;
				end else if (!phase_q) begin
					phase_q <= 1'b1;
					dividend_q <= {11'd0, diff_coef, 24'd0};
					rem_q <= '0;
					bit_q <= 7'd67;
				end
			end
			S_WR: begin
				e_mem[idx_q] <= e_res;
				u_mem[idx_q] <= u_res;
				xn_q <= e_res;
			end
			S_BRD: begin
				e_rd_q <= e_mem[j_q];
				u_rd_q <= u_mem[j_q];
			end
			S_BMUL: p1_q <= 64'(u_rd_q) * 64'(xn_q);
			S_BWR: begin
				xn_q <= (xs_c[40:32] != 9'd0) ? 32'hFFFF_FFFF : xs_c[31:0];
				e_mem[j_q] <= (xs_c[40:32] != 9'd0) ? 32'hFFFF_FFFF : xs_c[31:0];
			end
			S_ORD: density_out <= e_mem[j_q];
			default: ;
		endcase
		if (st_q == S_DEN) begin
			qe_q <= '0;
			qu_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			idx_q <= '0;
			j_q <= '0;
			n1_q <= '0;
			out_valid <= 1'b0;
			voxel_pos <= '0;
			last <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: if (q_valid) begin
					st_q <= q_item.first ? S_MUL : S_RD;
					if (q_item.first) idx_q <= '0;
				end
				S_RD: st_q <= S_MUL;
				S_MUL: st_q <= S_DEN;
				S_DEN: st_q <= S_DIV;
				S_DIV: if (bit_q == 7'd0 && phase_q) st_q <= S_WR;
				S_WR: begin
					if (!it_q.close) begin
						idx_q <= idx_q + AW'(1);
						st_q <= S_IDLE;
					end else begin
						n1_q <= idx_q;
						if (idx_q == '0) begin
							j_q <= '0;
							st_q <= S_ORD;
						end else begin
							j_q <= idx_q - AW'(1);
							st_q <= S_BRD;
						end
					end
				end
				S_BRD: st_q <= S_BMUL;
				S_BMUL: st_q <= S_BWR;
				S_BWR: begin
					if (j_q == '0) st_q <= S_ORD;
					else begin
						j_q <= j_q - AW'(1);
						st_q <= S_BRD;
					end
				end
				S_ORD: begin
					out_valid <= 1'b1;
					voxel_pos <= 6'(j_q);
					last <= (j_q == n1_q);
					st_q <= S_OUT;
				end
				S_OUT: if (!out_stall) begin
					out_valid <= 1'b0;
					if (last) begin
						idx_q <= '0;
						st_q <= S_IDLE;
					end else begin
						j_q <= j_q + AW'(1);
						st_q <= S_ORD;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`IDLS_ASSERT_IMPL(a_out_only_emit, clk, arst_n, out_valid |-> st_q == S_OUT)
	`IDLS_ASSERT_IMPL(a_take_idle, clk, arst_n, q_take |=> st_q != S_IDLE)
	`IDLS_NEVER(a_pos_range, clk, arst_n, out_valid && (j_q > n1_q))
	`IDLS_ASSERT_IMPL(a_den_ge_one, clk, arst_n, st_q == S_DIV |-> den_q >= idls_pkg::ONE_Q24)
endmodule
